// File: rtl/lm3_pkg.sv
// Shared constants and register codes for the 3x3 local maximum detector.
`default_nettype none

package lm3_pkg;

    // Configuration register data width and index width
    localparam int CFG_BITS       = 11;
    localparam int CFG_INDEX_BITS = 1;

    // Fixed widths of the reported peak coordinates
    localparam int ROW_BITS = 10;
    localparam int COL_BITS = 10;

    // Most results one pixel can cause
    localparam int MAX_RESULTS = 4;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

endpackage

`default_nettype wire

// File: rtl/local_maximum_3x3_detector_top.sv
// Streaming 3x3 local maximum detector: line buffers, window and result queue.
`default_nettype none

// Accepts one signed pixel per clock in raster order (stalled while the result register
// is busy) and reports every pixel that is not less than any of its existing eight
// neighbors (ties count, border pixels compare only with neighbors inside the image)
// with its value, row and column. A pixel waits in the input register, where two simple
// dual-port line buffers (MAX_WIDTH deep, read on accept, write-to-read forwarding) feed
// the 3x3 window and four center tests. Its results, zero to four, go to a small result
// register that hands out one per cycle while peak_ready is high, with last on the final
// one of the pixel; the next pixel moves in as the last is taken. The sustained rate is
// one pixel per clock, but one result per clock at row ends and in the last row.
// The image geometry is set by two registers (width at index 0, height at index 1;
// zero acts as one, values above the maximum act as the maximum) and may only change
// between images. No clearing pass is needed after reset.
module local_maximum_3x3_detector_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration write channel
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [lm3_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [lm3_pkg::CFG_BITS-1:0]        cfg_data,
    // pixel input channel
    input  wire logic                                pixel_valid,
    output logic                                     pixel_ready,
    input  wire logic signed [PIXEL_BITS-1:0]        pixel_value,
    // peak output channel
    output logic                                     peak_valid,
    input  wire logic                                peak_ready,
    output logic signed [PIXEL_BITS-1:0]             peak_value,
    output logic [lm3_pkg::ROW_BITS-1:0]             peak_row,
    output logic [lm3_pkg::COL_BITS-1:0]             peak_col,
    output logic                                     last
);

    import lm3_pkg::*;

    localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int LWW  = (CW + 1 > CFG_BITS) ? CW + 1 : CFG_BITS;
    localparam int LWH  = (RW + 1 > CFG_BITS) ? RW + 1 : CFG_BITS;
    localparam int NB   = $clog2(MAX_RESULTS + 1);
    localparam int IB   = $clog2(MAX_RESULTS);

    typedef logic signed [PIXEL_BITS-1:0] win_t [3][3];

    typedef struct packed {
        logic signed [PIXEL_BITS-1:0] value;
        logic [ROW_BITS-1:0]          row;
        logic [COL_BITS-1:0]          col;
    } peak_t;

    // Test one window center against the neighbors that exist
    function automatic logic is_peak(input win_t wv, input int r, input int c,
                                     input logic up, input logic down,
                                     input logic left, input logic right);
        logic res;
        int   rr;
        int   cc;
        res = 1'b1;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                rr = r + dr;
                cc = c + dc;
                if (!(dr == 0 && dc == 0) && !(dr < 0 && !up) && !(dr > 0 && !down) &&
                    !(dc < 0 && !left) && !(dc > 0 && !right) &&
                    rr >= 0 && rr <= 2 && cc >= 0 && cc <= 2) begin
                    if (wv[rr][cc] > wv[r][c]) begin
                        res = 1'b0;
                    end
                end
            end
        end
        return res;
    endfunction

    // Configuration registers
    logic [CFG_BITS-1:0] width_cfg_reg;
    logic [CFG_BITS-1:0] height_cfg_reg;

    // Position of the next pixel
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    // Input register
    logic                         s1_valid_reg;
    logic signed [PIXEL_BITS-1:0] s1_pix_reg;
    logic [CW-1:0]                s1_col_reg;
    logic [RW-1:0]                s1_row_reg;
    logic                         s1_end_row_reg;
    logic                         s1_last_row_reg;

    // Line buffers, read data and forwarding
    logic [PIXEL_BITS-1:0] older_mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] prior_mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] older_rd_reg, prior_rd_reg;
    logic                  byp_reg;
    logic [PIXEL_BITS-1:0] byp_older_reg, byp_prior_reg;
    logic [PIXEL_BITS-1:0] older_rd, prior_rd;

    // Window
    win_t window_reg;
    win_t window_next;

    // Result register
    peak_t         res_reg [MAX_RESULTS];
    peak_t         res_next [MAX_RESULTS];
    logic [NB-1:0] cnt_reg, cnt_next;
    logic [IB-1:0] idx_reg;

    // Handshake and geometry
    logic            accept;
    logic            advance;
    logic            out_fire;
    logic            out_last;
    logic            buf_free;
    logic [LWW-1:0]  width_lim;
    logic [LWH-1:0]  height_lim;
    logic [LWW-1:0]  width_ext;
    logic [LWH-1:0]  height_ext;
    logic            end_row;
    logic            last_row;

    // Center tests and coordinates
    logic                  j_ge1, j_ge2, i_ge1, i_ge2;
    logic [CW+COL_BITS-1:0] col_wide;
    logic [RW+ROW_BITS-1:0] row_wide;
    logic [COL_BITS-1:0]   col10, col10_m1;
    logic [ROW_BITS-1:0]   row10, row10_m1;
    logic [MAX_RESULTS-1:0] hit;
    peak_t                 cand [MAX_RESULTS];

    assign cfg_ready = 1'b1;

    // Clamp geometry and classify the arriving pixel
    always_comb
    begin
        width_ext  = LWW'(width_cfg_reg);
        height_ext = LWH'(height_cfg_reg);
        if (width_ext == '0) begin
            width_lim = LWW'(1);
        end else if (width_ext > LWW'(MAX_WIDTH)) begin
            width_lim = LWW'(MAX_WIDTH);
        end else begin
            width_lim = width_ext;
        end
        if (height_ext == '0) begin
            height_lim = LWH'(1);
        end else if (height_ext > LWH'(MAX_HEIGHT)) begin
            height_lim = LWH'(MAX_HEIGHT);
        end else begin
            height_lim = height_ext;
        end
        end_row  = LWW'(col_reg) >= (width_lim - LWW'(1));
        last_row = LWH'(row_reg) >= (height_lim - LWH'(1));
    end

    // Advance the position counters
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (end_row) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + RW'(1);
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    // Handshake: stage moves when the result register frees up
    assign out_fire    = peak_valid && peak_ready;
    assign out_last    = ({1'b0, idx_reg} == (cnt_reg - NB'(1)));
    assign buf_free    = (cnt_reg == '0) || (out_fire && out_last);
    assign advance     = s1_valid_reg && buf_free;
    assign pixel_ready = !s1_valid_reg || advance;
    assign accept      = pixel_valid && pixel_ready;

    // Forward a same-address write into the read data
    assign older_rd = byp_reg ? byp_older_reg : older_rd_reg;
    assign prior_rd = byp_reg ? byp_prior_reg : prior_rd_reg;

    // Shift the window and bring in the new column
    always_comb
    begin
        window_next = window_reg;
        for (int r = 0; r < 3; r++) begin
            window_next[r][0] = window_reg[r][1];
            window_next[r][1] = window_reg[r][2];
        end
        window_next[0][2] = older_rd;
        window_next[1][2] = prior_rd;
        window_next[2][2] = s1_pix_reg;
    end

    // Build the candidate peaks in emission order
    always_comb
    begin
        j_ge1    = (s1_col_reg != '0);
        j_ge2    = j_ge1 && (s1_col_reg != CW'(1));
        i_ge1    = (s1_row_reg != '0);
        i_ge2    = i_ge1 && (s1_row_reg != RW'(1));
        col_wide = {{COL_BITS{1'b0}}, s1_col_reg};
        row_wide = {{ROW_BITS{1'b0}}, s1_row_reg};
        col10    = col_wide[COL_BITS-1:0];
        row10    = row_wide[ROW_BITS-1:0];
        col10_m1 = col10 - COL_BITS'(1);
        row10_m1 = row10 - ROW_BITS'(1);

        hit[0] = i_ge1 && j_ge1 &&
                 is_peak(window_next, 1, 1, i_ge2, 1'b1, j_ge2, 1'b1);
        hit[1] = i_ge1 && s1_end_row_reg &&
                 is_peak(window_next, 1, 2, i_ge2, 1'b1, j_ge1, 1'b0);
        hit[2] = s1_last_row_reg && j_ge1 &&
                 is_peak(window_next, 2, 1, i_ge1, 1'b0, j_ge2, 1'b1);
        hit[3] = s1_last_row_reg && s1_end_row_reg &&
                 is_peak(window_next, 2, 2, i_ge1, 1'b0, j_ge1, 1'b0);

        cand[0] = '{value: window_next[1][1], row: row10_m1, col: col10_m1};
        cand[1] = '{value: window_next[1][2], row: row10_m1, col: col10};
        cand[2] = '{value: window_next[2][1], row: row10,    col: col10_m1};
        cand[3] = '{value: window_next[2][2], row: row10,    col: col10};
    end

    // Pack the hits into consecutive result slots
    always_comb
    begin
        cnt_next = '0;
        for (int k = 0; k < MAX_RESULTS; k++) begin
            res_next[k] = cand[k];
        end
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (hit[k]) begin
                res_next[cnt_next[IB-1:0]] = cand[k];
                cnt_next = cnt_next + NB'(1);
            end
        end
    end

    // Present the current result
    assign peak_valid = (cnt_reg != '0);
    assign peak_value = res_reg[idx_reg].value;
    assign peak_row   = res_reg[idx_reg].row;
    assign peak_col   = res_reg[idx_reg].col;
    assign last       = out_last;

    // Hold configuration, counters, input stage, window and result control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            width_cfg_reg   <= CFG_BITS'(8);
            height_cfg_reg  <= CFG_BITS'(8);
            col_reg         <= '0;
            row_reg         <= '0;
            s1_valid_reg    <= 1'b0;
            byp_reg         <= 1'b0;
            cnt_reg         <= '0;
            idx_reg         <= '0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    window_reg[r][c] <= '0;
                end
            end
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_IMAGE_WIDTH:  width_cfg_reg  <= cfg_data;
                    REG_IMAGE_HEIGHT: height_cfg_reg <= cfg_data;
                    default:          ;
                endcase
            end
            col_reg <= col_next;
            row_reg <= row_next;
            if (accept) begin
                s1_valid_reg <= 1'b1;
                byp_reg      <= advance && (s1_col_reg == col_reg);
            end else if (advance) begin
                s1_valid_reg <= 1'b0;
            end
            if (advance) begin
                window_reg <= window_next;
                cnt_reg    <= cnt_next;
                idx_reg    <= '0;
            end else if (out_fire) begin
                if (out_last) begin
                    cnt_reg <= '0;
                end else begin
                    idx_reg <= idx_reg + IB'(1);
                end
            end
        end
    end

    // Capture the input item payload
    always_ff @(posedge clk)
    begin
        if (accept) begin
            s1_pix_reg      <= pixel_value;
            s1_col_reg      <= col_reg;
            s1_row_reg      <= row_reg;
            s1_end_row_reg  <= end_row;
            s1_last_row_reg <= last_row;
            byp_older_reg   <= prior_rd;
            byp_prior_reg   <= s1_pix_reg;
        end
    end

    // Load the result slots
    always_ff @(posedge clk)
    begin
        if (advance) begin
            for (int k = 0; k < MAX_RESULTS; k++) begin
                res_reg[k] <= res_next[k];
            end
        end
    end

    // Write the line buffers as the window advances
    always_ff @(posedge clk)
    begin
        if (advance) begin
            older_mem[s1_col_reg] <= prior_rd;
            prior_mem[s1_col_reg] <= s1_pix_reg;
        end
    end

    // Read the line buffers as a pixel is accepted, ahead of use
    always_ff @(posedge clk)
    begin
        if (accept) begin
            older_rd_reg <= older_mem[col_reg];
            prior_rd_reg <= prior_mem[col_reg];
        end
    end

endmodule

`default_nettype wire
